[design/hag_pkg.sv]
// Shared types, constants and the sequencer microprogram of the Heun adjoint gradient unit.
`default_nettype none

package hag_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 24;
  localparam int RegAw     = 5;
  localparam int RegDepth  = 32;
  localparam int PcW       = 6;
  localparam int CntW      = 16;
  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 32;

  typedef logic signed [DataWidth-1:0] word_t;
  typedef logic [RegAw-1:0]            raddr_t;
  typedef logic [PcW-1:0]              pc_t;

  typedef struct packed {
    word_t init_disp;
    word_t init_vel;
    word_t observed_final;
  } hag_in_t;

  typedef struct packed {
    word_t grad_disp;
    logic  saturated;
  } hag_out_t;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_NATURAL_FREQ  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE     = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP_COUNT    = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_DAMPING_RATIO = 8'd3;

  localparam logic [30:0] NATURAL_FREQ_RST  = 31'd33554432;
  localparam logic [23:0] STEP_SIZE_RST     = 24'd167772;
  localparam logic [15:0] STEP_COUNT_RST    = 16'd1000;
  localparam logic [15:0] DAMPING_RATIO_RST = 16'd6554;

  localparam word_t FIX_ONE = word_t'(64'(1) << FracBits);

  // Operation codes of the shared unit.
  localparam logic [2:0] OP_LD  = 3'd0;
  localparam logic [2:0] OP_MUL = 3'd1;
  localparam logic [2:0] OP_ADD = 3'd2;
  localparam logic [2:0] OP_SUB = 3'd3;
  localparam logic [2:0] OP_OUT = 3'd4;

  // Program flow codes at the end of an instruction.
  localparam logic [2:0] NX_SEQ       = 3'd0;
  localparam logic [2:0] NX_FWD_ENTER = 3'd1;
  localparam logic [2:0] NX_FWD_LOOP  = 3'd2;
  localparam logic [2:0] NX_BWD_ENTER = 3'd3;
  localparam logic [2:0] NX_BWD_LOOP  = 3'd4;

  // Register file slots.
  localparam raddr_t R_ONE  = 5'd0;
  localparam raddr_t R_ZERO = 5'd1;
  localparam raddr_t R_OM   = 5'd2;
  localparam raddr_t R_H    = 5'd3;
  localparam raddr_t R_ZE   = 5'd4;
  localparam raddr_t R_X    = 5'd5;
  localparam raddr_t R_V    = 5'd6;
  localparam raddr_t R_OBS  = 5'd7;
  localparam raddr_t R_A    = 5'd8;
  localparam raddr_t R_B    = 5'd9;
  localparam raddr_t R_S1V  = 5'd10;
  localparam raddr_t R_TX   = 5'd11;
  localparam raddr_t R_TV   = 5'd12;
  localparam raddr_t R_S2V  = 5'd13;
  localparam raddr_t R_T1   = 5'd14;
  localparam raddr_t R_T2   = 5'd15;
  localparam raddr_t R_Q    = 5'd16;
  localparam raddr_t R_QA   = 5'd17;
  localparam raddr_t R_J0   = 5'd18;
  localparam raddr_t R_J1   = 5'd19;
  localparam raddr_t R_J2   = 5'd20;
  localparam raddr_t R_J3   = 5'd21;
  localparam raddr_t R_L0   = 5'd22;
  localparam raddr_t R_L1   = 5'd23;
  localparam raddr_t R_P0   = 5'd24;

  localparam pc_t PC_FWD   = 6'd11;
  localparam pc_t PC_SETUP = 6'd29;
  localparam pc_t PC_BWD   = 6'd46;
  localparam pc_t PC_OUT   = 6'd53;

  typedef struct packed {
    logic [2:0] op;
    raddr_t     dst;
    raddr_t     sa;
    raddr_t     sb;
    logic       half;
    logic [2:0] nxt;
  } uinstr_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    raddr_t     raddr_a;
    raddr_t     raddr_b;
    raddr_t     waddr;
    logic       wen;
    logic       ex;
    logic [2:0] op;
    logic       half;
    logic       out_take;
  } seq_ctl_t;

  function automatic uinstr_t mk(logic [2:0] op, raddr_t dst, raddr_t sa, raddr_t sb,
                                 logic half, logic [2:0] nxt);
    uinstr_t u;
    u.op   = op;
    u.dst  = dst;
    u.sa   = sa;
    u.sb   = sb;
    u.half = half;
    u.nxt  = nxt;
    return u;
  endfunction

  // A half flag set means the product carries one extra fraction bit (the h/2 factor).
  function automatic uinstr_t ucode(pc_t pc);
    uinstr_t u;
    unique case (pc)
      // Load constants, configuration and item fields.
      6'd0:  u = mk(OP_LD,  R_ONE,  R_ZERO, R_ZERO, 1'b0, NX_SEQ);
      6'd1:  u = mk(OP_LD,  R_ZERO, R_ZERO, R_ZERO, 1'b0, NX_SEQ);
      6'd2:  u = mk(OP_LD,  R_OM,   R_ZERO, R_ZERO, 1'b0, NX_SEQ);
      6'd3:  u = mk(OP_LD,  R_H,    R_ZERO, R_ZERO, 1'b0, NX_SEQ);
      6'd4:  u = mk(OP_LD,  R_ZE,   R_ZERO, R_ZERO, 1'b0, NX_SEQ);
      6'd5:  u = mk(OP_LD,  R_X,    R_ZERO, R_ZERO, 1'b0, NX_SEQ);
      6'd6:  u = mk(OP_LD,  R_V,    R_ZERO, R_ZERO, 1'b0, NX_SEQ);
      6'd7:  u = mk(OP_LD,  R_OBS,  R_ZERO, R_ZERO, 1'b0, NX_SEQ);
      // a = omega^2, b = 2 zeta omega.
      6'd8:  u = mk(OP_MUL, R_A,    R_OM,   R_OM,   1'b0, NX_SEQ);
      6'd9:  u = mk(OP_MUL, R_B,    R_ZE,   R_OM,   1'b0, NX_SEQ);
      6'd10: u = mk(OP_ADD, R_B,    R_B,    R_B,    1'b0, NX_FWD_ENTER);
      // One forward Heun step.
      6'd11: u = mk(OP_MUL, R_T1,   R_B,    R_V,    1'b0, NX_SEQ);
      6'd12: u = mk(OP_SUB, R_T1,   R_ZERO, R_T1,   1'b0, NX_SEQ);
      6'd13: u = mk(OP_MUL, R_T2,   R_A,    R_X,    1'b0, NX_SEQ);
      6'd14: u = mk(OP_SUB, R_S1V,  R_T1,   R_T2,   1'b0, NX_SEQ);
      6'd15: u = mk(OP_MUL, R_T1,   R_H,    R_V,    1'b0, NX_SEQ);
      6'd16: u = mk(OP_ADD, R_TX,   R_X,    R_T1,   1'b0, NX_SEQ);
      6'd17: u = mk(OP_MUL, R_T1,   R_H,    R_S1V,  1'b0, NX_SEQ);
      6'd18: u = mk(OP_ADD, R_TV,   R_V,    R_T1,   1'b0, NX_SEQ);
      6'd19: u = mk(OP_MUL, R_T1,   R_B,    R_TV,   1'b0, NX_SEQ);
      6'd20: u = mk(OP_SUB, R_T1,   R_ZERO, R_T1,   1'b0, NX_SEQ);
      6'd21: u = mk(OP_MUL, R_T2,   R_A,    R_TX,   1'b0, NX_SEQ);
      6'd22: u = mk(OP_SUB, R_S2V,  R_T1,   R_T2,   1'b0, NX_SEQ);
      6'd23: u = mk(OP_ADD, R_T1,   R_V,    R_TV,   1'b0, NX_SEQ);
      6'd24: u = mk(OP_MUL, R_T1,   R_H,    R_T1,   1'b1, NX_SEQ);
      6'd25: u = mk(OP_ADD, R_X,    R_X,    R_T1,   1'b0, NX_SEQ);
      6'd26: u = mk(OP_ADD, R_T1,   R_S1V,  R_S2V,  1'b0, NX_SEQ);
      6'd27: u = mk(OP_MUL, R_T1,   R_H,    R_T1,   1'b1, NX_SEQ);
      6'd28: u = mk(OP_ADD, R_V,    R_V,    R_T1,   1'b0, NX_FWD_LOOP);
      // Transposed transition matrix and terminal adjoint.
      6'd29: u = mk(OP_MUL, R_Q,    R_H,    R_H,    1'b1, NX_SEQ);
      6'd30: u = mk(OP_MUL, R_QA,   R_Q,    R_A,    1'b0, NX_SEQ);
      6'd31: u = mk(OP_SUB, R_J0,   R_ONE,  R_QA,   1'b0, NX_SEQ);
      6'd32: u = mk(OP_MUL, R_T1,   R_H,    R_A,    1'b0, NX_SEQ);
      6'd33: u = mk(OP_SUB, R_T1,   R_ZERO, R_T1,   1'b0, NX_SEQ);
      6'd34: u = mk(OP_MUL, R_T2,   R_QA,   R_B,    1'b0, NX_SEQ);
      6'd35: u = mk(OP_ADD, R_J1,   R_T1,   R_T2,   1'b0, NX_SEQ);
      6'd36: u = mk(OP_MUL, R_T1,   R_Q,    R_B,    1'b0, NX_SEQ);
      6'd37: u = mk(OP_SUB, R_J2,   R_H,    R_T1,   1'b0, NX_SEQ);
      6'd38: u = mk(OP_MUL, R_T1,   R_H,    R_B,    1'b0, NX_SEQ);
      6'd39: u = mk(OP_SUB, R_T1,   R_ONE,  R_T1,   1'b0, NX_SEQ);
      6'd40: u = mk(OP_MUL, R_T2,   R_B,    R_B,    1'b0, NX_SEQ);
      6'd41: u = mk(OP_SUB, R_T2,   R_T2,   R_A,    1'b0, NX_SEQ);
      6'd42: u = mk(OP_MUL, R_T2,   R_Q,    R_T2,   1'b0, NX_SEQ);
      6'd43: u = mk(OP_ADD, R_J3,   R_T1,   R_T2,   1'b0, NX_SEQ);
      6'd44: u = mk(OP_SUB, R_L0,   R_X,    R_OBS,  1'b0, NX_SEQ);
      6'd45: u = mk(OP_ADD, R_L1,   R_ZERO, R_ZERO, 1'b0, NX_BWD_ENTER);
      // One backward adjoint step.
      6'd46: u = mk(OP_MUL, R_T1,   R_J0,   R_L0,   1'b0, NX_SEQ);
      6'd47: u = mk(OP_MUL, R_T2,   R_J1,   R_L1,   1'b0, NX_SEQ);
      6'd48: u = mk(OP_ADD, R_P0,   R_T1,   R_T2,   1'b0, NX_SEQ);
      6'd49: u = mk(OP_MUL, R_T1,   R_J2,   R_L0,   1'b0, NX_SEQ);
      6'd50: u = mk(OP_MUL, R_T2,   R_J3,   R_L1,   1'b0, NX_SEQ);
      6'd51: u = mk(OP_ADD, R_L1,   R_T1,   R_T2,   1'b0, NX_SEQ);
      6'd52: u = mk(OP_ADD, R_L0,   R_P0,   R_ZERO, 1'b0, NX_BWD_LOOP);
      default: u = mk(OP_OUT, R_L0, R_L0,   R_ZERO, 1'b0, NX_SEQ);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

[design/hag_ram.sv]
// Generic register file RAM: one write port, two read ports with registered read data.
`default_nettype none

module hag_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

`default_nettype wire

[design/hag_alu.sv]
// Shared arithmetic unit: rounded saturating fixed-point multiply and saturating add/subtract.
`default_nettype none

module hag_alu import hag_pkg::*; (
  input  wire logic     clk,
  input  wire seq_ctl_t ctl,
  input  wire word_t    opa,
  input  wire word_t    opb,
  output word_t         res,
  output logic          sat
);

  localparam logic [63:0] RndLo  = 64'(1) << (FracBits - 1);
  localparam logic [63:0] RndHi  = 64'(1) << FracBits;
  localparam logic [63:0] MagMax = 64'(1) << (DataWidth - 1);

  logic [DataWidth-1:0]   ua;
  logic [DataWidth-1:0]   ub;
  logic [2*DataWidth-1:0] prod_nxt;
  logic [DataWidth:0]     sum_ext;
  word_t                  sum_nxt;
  logic                   sum_ovf;

  logic [2*DataWidth-1:0] prod_r;
  logic                   neg_r;
  logic                   half_r;
  logic                   mul_r;
  word_t                  sum_r;
  logic                   sumsat_r;

  logic [63:0]            rounded;
  logic [63:0]            mag;
  logic [63:0]            lim;
  word_t                  mul_res;
  logic                   mul_sat;

  // First stage: magnitudes into the multiplier, or the wide add.
  always_comb begin
    ua       = opa[DataWidth-1] ? (~opa + 1'b1) : opa;
    ub       = opb[DataWidth-1] ? (~opb + 1'b1) : opb;
    prod_nxt = ua * ub;
    if (ctl.op == OP_SUB) begin
      sum_ext = {opa[DataWidth-1], opa} - {opb[DataWidth-1], opb};
    end else begin
      sum_ext = {opa[DataWidth-1], opa} + {opb[DataWidth-1], opb};
    end
    sum_ovf = sum_ext[DataWidth] != sum_ext[DataWidth-1];
    if (!sum_ovf) begin
      sum_nxt = sum_ext[DataWidth-1:0];
    end else if (sum_ext[DataWidth]) begin
      sum_nxt = {1'b1, {(DataWidth-1){1'b0}}};
    end else begin
      sum_nxt = {1'b0, {(DataWidth-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ex) begin
      prod_r   <= prod_nxt;
      neg_r    <= opa[DataWidth-1] ^ opb[DataWidth-1];
      half_r   <= ctl.half;
      mul_r    <= ctl.op == OP_MUL;
      sum_r    <= sum_nxt;
      sumsat_r <= sum_ovf;
    end
  end

  // Second stage: round half away from zero on the magnitude, then clamp and restore the sign.
  always_comb begin
    if (half_r) begin
      rounded = 64'(prod_r) + RndHi;
      mag     = rounded >> (FracBits + 1);
    end else begin
      rounded = 64'(prod_r) + RndLo;
      mag     = rounded >> FracBits;
    end
    lim     = neg_r ? MagMax : MagMax - 64'd1;
    mul_sat = mag > lim;
    if (mul_sat) begin
      mul_res = neg_r ? {1'b1, {(DataWidth-1){1'b0}}} : {1'b0, {(DataWidth-1){1'b1}}};
    end else if (neg_r) begin
      mul_res = word_t'({DataWidth{1'b0}} - mag[DataWidth-1:0]);
    end else begin
      mul_res = mag[DataWidth-1:0];
    end
    res = mul_r ? mul_res : sum_r;
    sat = mul_r ? mul_sat : sumsat_r;
  end

endmodule

`default_nettype wire

[design/hag_seq.sv]
// Microprogram sequencer: steps read, execute and write-back phases and runs the step loops.
`default_nettype none

module hag_seq import hag_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [CntW-1:0] step_count,
  input  wire logic            out_free,
  output logic                 busy,
  output seq_ctl_t             ctl
);

  localparam logic [1:0] PH_RD = 2'd0;
  localparam logic [1:0] PH_EX = 2'd1;
  localparam logic [1:0] PH_WB = 2'd2;

  logic            busy_r;
  logic            busy_nxt;
  logic [1:0]      ph_r;
  logic [1:0]      ph_nxt;
  pc_t             pc_r;
  pc_t             pc_nxt;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;
  uinstr_t         instr;
  logic            last_iter;

  assign instr     = ucode(pc_r);
  assign busy      = busy_r;
  assign last_iter = (cnt_r + 1'b1) == step_count;

  always_comb begin
    ctl.raddr_a  = instr.sa;
    ctl.raddr_b  = instr.sb;
    ctl.waddr    = instr.dst;
    ctl.op       = instr.op;
    ctl.half     = instr.half;
    ctl.ex       = busy_r && (ph_r == PH_EX) && (instr.op != OP_OUT);
    ctl.wen      = busy_r && (ph_r == PH_WB);
    ctl.out_take = busy_r && (ph_r == PH_EX) && (instr.op == OP_OUT) && out_free;
  end

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    pc_nxt   = pc_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      ph_nxt   = PH_RD;
      pc_nxt   = '0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      unique case (ph_r)
        PH_RD: begin
          ph_nxt = PH_EX;
        end
        PH_EX: begin
          // The final instruction waits here until the output register can take the item.
          if (instr.op == OP_OUT) begin
            if (out_free) begin
              busy_nxt = 1'b0;
              ph_nxt   = PH_RD;
            end
          end else begin
            ph_nxt = PH_WB;
          end
        end
        PH_WB: begin
          ph_nxt = PH_RD;
          unique case (instr.nxt)
            NX_SEQ: begin
              pc_nxt = pc_r + 1'b1;
            end
            NX_FWD_ENTER: begin
              cnt_nxt = '0;
              pc_nxt  = (step_count == '0) ? PC_SETUP : PC_FWD;
            end
            NX_FWD_LOOP: begin
              if (last_iter) begin
                cnt_nxt = '0;
                pc_nxt  = PC_SETUP;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
                pc_nxt  = PC_FWD;
              end
            end
            NX_BWD_ENTER: begin
              cnt_nxt = '0;
              pc_nxt  = (step_count == '0) ? PC_OUT : PC_BWD;
            end
            NX_BWD_LOOP: begin
              if (last_iter) begin
                cnt_nxt = '0;
                pc_nxt  = PC_OUT;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
                pc_nxt  = PC_BWD;
              end
            end
            default: begin
              pc_nxt = pc_r + 1'b1;
            end
          endcase
        end
        default: begin
          ph_nxt = PH_RD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= PH_RD;
      pc_r   <= '0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[design/heun_adjoint_gradient_unit.sv]
// Top level of the Heun adjoint gradient unit: configuration, item capture, register file, output.
//
//   channel   ports                                 direction   item
//   in        in_valid / in_ready / in_data         input       hag_in_t
//   out       out_valid / out_ready / out_data      output      hag_out_t
//   cfg       cfg_valid / cfg_ready / cfg_index,    input       register write
//             cfg_data
//
// Every microinstruction runs a register file read, a shared unit and a write-back phase (the
// final output instruction ends after its shared unit phase), with one multiplier and one adder
// in the shared unit. An item runs the loads, N forward steps, the matrix setup, N backward steps
// and the output hand-off.
// Reset is synchronous and active low; it restores the configuration and idles the sequencer.
// in_ready is low while an item is in work; a result left waiting on out_ready does not block the
// next item until that item is finished. Configuration writes are always taken.
`default_nettype none

module heun_adjoint_gradient_unit import hag_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hag_in_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hag_out_t                 out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  logic [30:0]     natural_freq_r;
  logic [23:0]     step_size_r;
  logic [15:0]     step_count_r;
  logic [15:0]     damping_ratio_r;

  hag_in_t         item_r;
  logic            sat_r;
  logic            out_valid_r;
  hag_out_t        out_data_r;

  logic            busy;
  logic            start;
  logic            out_free;
  seq_ctl_t        ctl;
  word_t           rdata_a;
  word_t           rdata_b;
  word_t           alu_res;
  logic            alu_sat;
  word_t           ld_val;
  word_t           wdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign start     = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      natural_freq_r  <= NATURAL_FREQ_RST;
      step_size_r     <= STEP_SIZE_RST;
      step_count_r    <= STEP_COUNT_RST;
      damping_ratio_r <= DAMPING_RATIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_NATURAL_FREQ) begin
        natural_freq_r <= cfg_data[30:0];
      end
      if (cfg_index == CFG_STEP_SIZE) begin
        step_size_r <= cfg_data[23:0];
      end
      if (cfg_index == CFG_STEP_COUNT) begin
        step_count_r <= cfg_data[15:0];
      end
      if (cfg_index == CFG_DAMPING_RATIO) begin
        damping_ratio_r <= cfg_data[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item_r <= in_data;
    end
  end

  // Load values in the working format; zeta moves from 16 to 24 fraction bits.
  always_comb begin
    unique case (ctl.waddr)
      R_ONE:   ld_val = FIX_ONE;
      R_OM:    ld_val = {1'b0, natural_freq_r};
      R_H:     ld_val = {8'b0, step_size_r};
      R_ZE:    ld_val = {8'b0, damping_ratio_r, 8'b0};
      R_X:     ld_val = item_r.init_disp;
      R_V:     ld_val = item_r.init_vel;
      R_OBS:   ld_val = item_r.observed_final;
      default: ld_val = '0;
    endcase
    wdata = (ctl.op == OP_LD) ? ld_val : alu_res;
  end

  hag_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .step_count (step_count_r),
    .out_free   (out_free),
    .busy       (busy),
    .ctl        (ctl)
  );

  hag_ram #(
    .WIDTH (DataWidth),
    .DEPTH (RegDepth)
  ) u_regs (
    .clk     (clk),
    .we      (ctl.wen),
    .waddr   (ctl.waddr),
    .wdata   (wdata),
    .raddr_a (ctl.raddr_a),
    .raddr_b (ctl.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  hag_alu u_alu (
    .clk (clk),
    .ctl (ctl),
    .opa (rdata_a),
    .opb (rdata_b),
    .res (alu_res),
    .sat (alu_sat)
  );

  // The saturation flag is sticky over all operations of one item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (start) begin
      sat_r <= 1'b0;
    end else if (ctl.wen && (ctl.op != OP_LD)) begin
      sat_r <= sat_r | alu_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_take) begin
      out_data_r.grad_disp <= rdata_a;
      out_data_r.saturated <= sat_r;
    end
  end

endmodule

`default_nettype wire
